[rtl/fprs_pkg.sv]
package fprs_pkg;

  localparam int RING_MAX_DEFAULT = 16;
  localparam int PLAYLIST_MAX_DEFAULT = 1024;

  localparam logic [2:0] OP_WRITE = 3'd0;
  localparam logic [2:0] OP_START = 3'd1;
  localparam logic [2:0] OP_TICK = 3'd2;
  localparam logic [2:0] OP_DONE = 3'd3;
  localparam logic [2:0] OP_SAMPLER = 3'd4;

  localparam logic [1:0] REG_PLAYLIST_LENGTH = 2'd0;
  localparam logic [1:0] REG_RING_SIZE = 2'd1;
  localparam logic [1:0] REG_INITIAL_SAMPLER = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_READ,
    ST_DECIDE,
    ST_STATUS,
    ST_WALK,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic prep;
    logic fold;
    logic read;
    logic decide;
    logic status;
    logic walk_step;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic walk_any;
    logic walk_done;
    logic fold_need;
    logic fold_done;
  } stat_t;

endpackage

[rtl/frame_prefetch_ring_scheduler.sv]
// Frame playback sequencer with a prefetch ring. Drive an item with start while busy
// is low; results then appear one per strobe, each valid for exactly one cycle, and
// the receiver cannot stall them. Every item yields a status result first, then fetch
// requests in ring order, and the final result carries last. Busy stays high until the
// item is finished; an item that walks the ring steps through each ring position
// (min(ring_size, playlist_length)) and then releases the final result, which is held
// back until the walk shows it is the last. After a register change that leaves a
// pointer outside its range, the pointer fold does up to one compare and subtract
// per pointer bit.
module frame_prefetch_ring_scheduler #(
  parameter int RING_MAX = fprs_pkg::RING_MAX_DEFAULT,
  parameter int PLAYLIST_MAX = fprs_pkg::PLAYLIST_MAX_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data,
  input  logic [2:0]  opcode,
  input  logic [9:0]  entry_index,
  input  logic [31:0] duration_ms,
  input  logic [31:0] now_ms,
  input  logic [3:0]  slot_index,
  input  logic [15:0] generation_tag,
  input  logic        load_ok,
  input  logic [2:0]  new_sampler_type,
  output logic        result_valid,
  output logic        kind,
  output logic        advanced,
  output logic [9:0]  playback_index,
  output logic [3:0]  req_slot,
  output logic [9:0]  req_entry,
  output logic [2:0]  req_sampler_type,
  output logic [15:0] req_generation,
  output logic        last
);

  fprs_pkg::cmd_t  cmd;
  fprs_pkg::stat_t stat;

  fprs_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  fprs_dp #(
    .RING_MAX     (RING_MAX),
    .PLAYLIST_MAX (PLAYLIST_MAX)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .opcode           (opcode),
    .entry_index      (entry_index),
    .duration_ms      (duration_ms),
    .now_ms           (now_ms),
    .slot_index       (slot_index),
    .generation_tag   (generation_tag),
    .load_ok          (load_ok),
    .new_sampler_type (new_sampler_type),
    .result_valid     (result_valid),
    .kind             (kind),
    .advanced         (advanced),
    .playback_index   (playback_index),
    .req_slot         (req_slot),
    .req_entry        (req_entry),
    .req_sampler_type (req_sampler_type),
    .req_generation   (req_generation),
    .last             (last)
  );

endmodule

[rtl/fprs_ctrl.sv]
module fprs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  fprs_pkg::stat_t   stat,
  output fprs_pkg::cmd_t    cmd
);

  fprs_pkg::state_t state;
  fprs_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fprs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    busy = 1'b1;
    case (state)
      fprs_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.prep = 1'b1;
          state_next = fprs_pkg::ST_PREP;
        end
      end
      fprs_pkg::ST_PREP: begin
        // Pointers left outside the ring by a register change are folded back
        // one compare and subtract per cycle.
        if (stat.fold_need) begin
          cmd.fold = 1'b1;
          if (stat.fold_done) begin
            state_next = fprs_pkg::ST_READ;
          end
        end else begin
          state_next = fprs_pkg::ST_READ;
        end
      end
      fprs_pkg::ST_READ: begin
        cmd.read = 1'b1;
        state_next = fprs_pkg::ST_DECIDE;
      end
      fprs_pkg::ST_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = fprs_pkg::ST_STATUS;
      end
      fprs_pkg::ST_STATUS: begin
        cmd.status = 1'b1;
        state_next = stat.walk_any ? fprs_pkg::ST_WALK : fprs_pkg::ST_IDLE;
      end
      fprs_pkg::ST_WALK: begin
        cmd.walk_step = 1'b1;
        if (stat.walk_done) begin
          state_next = fprs_pkg::ST_FLUSH;
        end
      end
      fprs_pkg::ST_FLUSH: begin
        cmd.flush = 1'b1;
        state_next = fprs_pkg::ST_IDLE;
      end
      default: begin
        state_next = fprs_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/fprs_dp.sv]
module fprs_dp #(
  parameter int RING_MAX = fprs_pkg::RING_MAX_DEFAULT,
  parameter int PLAYLIST_MAX = fprs_pkg::PLAYLIST_MAX_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  fprs_pkg::cmd_t    cmd,
  output fprs_pkg::stat_t   stat,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [10:0]       cfg_data,
  input  logic [2:0]        opcode,
  input  logic [9:0]        entry_index,
  input  logic [31:0]       duration_ms,
  input  logic [31:0]       now_ms,
  input  logic [3:0]        slot_index,
  input  logic [15:0]       generation_tag,
  input  logic              load_ok,
  input  logic [2:0]        new_sampler_type,
  output logic              result_valid,
  output logic              kind,
  output logic              advanced,
  output logic [9:0]        playback_index,
  output logic [3:0]        req_slot,
  output logic [9:0]        req_entry,
  output logic [2:0]        req_sampler_type,
  output logic [15:0]       req_generation,
  output logic              last
);

  localparam int SW = (RING_MAX > 1) ? $clog2(RING_MAX) : 1;
  localparam int EW = $clog2(PLAYLIST_MAX);
  localparam int RW = $clog2(RING_MAX + 1);
  localparam int LW = $clog2(PLAYLIST_MAX + 1);
  localparam int FW = (EW > SW) ? EW : SW;
  localparam int KW = (FW > 1) ? $clog2(FW) : 1;

  logic [31:0] dur_mem [PLAYLIST_MAX];
  logic [31:0] dur_rd;

  logic [RING_MAX-1:0] slot_ready;
  logic [9:0]  slot_entry [RING_MAX];
  logic [15:0] slot_gen [RING_MAX];
  logic [RING_MAX-1:0] req_valid;
  logic [9:0]  req_ent [RING_MAX];
  logic [15:0] req_gen [RING_MAX];

  logic [10:0] playlist_length;
  logic [4:0]  ring_size;
  logic [SW-1:0] slot_ptr;
  logic [EW-1:0] entry_ptr;
  logic [15:0] cur_gen;
  logic [2:0]  cur_sampler;
  logic        sampler_changed;
  logic [31:0] frame_start;
  logic        start_valid;

  logic [2:0]  op_q;
  logic [9:0]  ent_q;
  logic [31:0] now_q;
  logic [3:0]  sidx_q;
  logic [15:0] gtag_q;
  logic        ok_q;
  logic [2:0]  nst_q;
  logic        adv;
  logic        walk_any;
  logic [RW-1:0] walk_cnt;
  logic [SW-1:0] ws;
  logic [EW-1:0] we;
  logic [KW-1:0] fold_cnt;

  logic        hold_kind;
  logic [3:0]  hold_slot;
  logic [9:0]  hold_entry;
  logic [2:0]  hold_stype;
  logic [15:0] hold_gen;

  logic [LW-1:0] len_eff;
  logic [RW-1:0] ring_eff;
  logic [SW-1:0] ns;
  logic [EW-1:0] ne;
  logic [31:0]   elapsed;
  logic          can_adv;
  logic          held;
  logic          pend;
  logic          emit;
  logic          walk_last;
  logic [SW-1:0] ws_inc;
  logic [EW-1:0] we_inc;
  logic [31:0]   len_step;
  logic [31:0]   ring_step;

  always_comb begin
    if (playlist_length == 11'd0) begin
      len_eff = LW'(1);
    end else if ({21'd0, playlist_length} > 32'(PLAYLIST_MAX)) begin
      len_eff = LW'(PLAYLIST_MAX);
    end else begin
      len_eff = LW'(playlist_length);
    end
    if (ring_size == 5'd0) begin
      ring_eff = RW'(1);
    end else if ({27'd0, ring_size} > 32'(RING_MAX)) begin
      ring_eff = RW'(RING_MAX);
    end else begin
      ring_eff = RW'(ring_size);
    end
    if (32'(ring_eff) > 32'(len_eff)) begin
      ring_eff = RW'(len_eff);
    end
  end

  assign ns = (32'(slot_ptr) + 1 >= 32'(ring_eff)) ? '0 : SW'(32'(slot_ptr) + 1);
  assign ne = (32'(entry_ptr) + 1 >= 32'(len_eff)) ? '0 : EW'(32'(entry_ptr) + 1);
  assign elapsed = now_q - frame_start;
  assign can_adv = start_valid && (elapsed >= dur_rd) && slot_ready[ns] &&
                   (32'(slot_entry[ns]) == 32'(ne)) && (slot_gen[ns] == cur_gen);

  assign held = slot_ready[ws] && (32'(slot_entry[ws]) == 32'(we)) &&
                (slot_gen[ws] == cur_gen);
  assign pend = req_valid[ws] && (32'(req_ent[ws]) == 32'(we)) &&
                (req_gen[ws] == cur_gen);
  assign emit = !held && !pend;
  assign walk_last = (32'(walk_cnt) + 1 >= 32'(ring_eff));
  assign ws_inc = (32'(ws) + 1 >= 32'(ring_eff)) ? '0 : SW'(32'(ws) + 1);
  assign we_inc = (32'(we) + 1 >= 32'(len_eff)) ? '0 : EW'(32'(we) + 1);

  // Remainder by shifted compare and subtract, from the top bit down.
  assign len_step = 32'(len_eff) << fold_cnt;
  assign ring_step = 32'(ring_eff) << fold_cnt;

  assign stat.walk_any = walk_any;
  assign stat.walk_done = walk_last;
  assign stat.fold_need = (32'(slot_ptr) >= 32'(ring_eff)) ||
                          (32'(entry_ptr) >= 32'(len_eff));
  assign stat.fold_done = (fold_cnt == '0);

  // Duration memory: written in the prep step, read with a registered port.
  always_ff @(posedge clk) begin
    if (cmd.prep && opcode == fprs_pkg::OP_WRITE && 32'(entry_index) < PLAYLIST_MAX) begin
      dur_mem[EW'(entry_index)] <= duration_ms;
    end
    if (cmd.read) begin
      dur_rd <= dur_mem[entry_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      op_q <= opcode;
      ent_q <= entry_index;
      now_q <= now_ms;
      sidx_q <= slot_index;
      gtag_q <= generation_tag;
      ok_q <= load_ok;
      nst_q <= new_sampler_type;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      playlist_length <= 11'd1;
      ring_size <= 5'd4;
      slot_ptr <= '0;
      entry_ptr <= '0;
      cur_gen <= '0;
      cur_sampler <= '0;
      sampler_changed <= 1'b0;
      frame_start <= '0;
      start_valid <= 1'b0;
      slot_ready <= '0;
      req_valid <= '0;
      adv <= 1'b0;
      walk_any <= 1'b0;
      walk_cnt <= '0;
      ws <= '0;
      we <= '0;
      fold_cnt <= '0;
      hold_kind <= 1'b0;
      hold_slot <= '0;
      hold_entry <= '0;
      hold_stype <= '0;
      hold_gen <= '0;
      result_valid <= 1'b0;
      for (int i = 0; i < RING_MAX; i++) begin
        slot_entry[i] <= '0;
        slot_gen[i] <= '0;
        req_ent[i] <= '0;
        req_gen[i] <= '0;
      end
    end else begin
      result_valid <= (cmd.status && !walk_any) || (cmd.walk_step && emit) || cmd.flush;
      if (cfg_we) begin
        case (cfg_index)
          fprs_pkg::REG_PLAYLIST_LENGTH: playlist_length <= cfg_data;
          fprs_pkg::REG_RING_SIZE: ring_size <= cfg_data[4:0];
          fprs_pkg::REG_INITIAL_SAMPLER: begin
            if (!sampler_changed) begin
              cur_sampler <= cfg_data[2:0];
            end
          end
          default: begin
          end
        endcase
      end
      if (cmd.prep) begin
        fold_cnt <= KW'(FW - 1);
        adv <= 1'b0;
        walk_any <= 1'b0;
      end
      if (cmd.fold) begin
        // Pointers left outside their range by a register change fold back into it.
        if (32'(entry_ptr) >= len_step) begin
          entry_ptr <= EW'(32'(entry_ptr) - len_step);
        end
        if (32'(slot_ptr) >= ring_step) begin
          slot_ptr <= SW'(32'(slot_ptr) - ring_step);
        end
        fold_cnt <= fold_cnt - KW'(1);
      end
      if (cmd.decide) begin
        case (op_q)
          fprs_pkg::OP_START: walk_any <= 1'b1;
          fprs_pkg::OP_TICK: begin
            if (!start_valid) begin
              frame_start <= now_q;
              start_valid <= 1'b1;
            end else if (can_adv) begin
              slot_ptr <= ns;
              entry_ptr <= ne;
              frame_start <= now_q;
              adv <= 1'b1;
              walk_any <= 1'b1;
            end
          end
          fprs_pkg::OP_DONE: begin
            if (ok_q && 32'(sidx_q) < 32'(ring_eff)) begin
              slot_ready[SW'(sidx_q)] <= 1'b1;
              slot_entry[SW'(sidx_q)] <= ent_q;
              slot_gen[SW'(sidx_q)] <= gtag_q;
            end
          end
          fprs_pkg::OP_SAMPLER: begin
            cur_sampler <= nst_q;
            sampler_changed <= 1'b1;
            cur_gen <= cur_gen + 16'd1;
            walk_any <= 1'b1;
          end
          default: begin
          end
        endcase
      end
      if (cmd.status) begin
        // Without a walk the status result goes out at once and closes the item;
        // otherwise it waits in the hold register until the next result is known.
        kind <= 1'b0;
        advanced <= adv;
        playback_index <= 10'(entry_ptr);
        req_slot <= '0;
        req_entry <= '0;
        req_sampler_type <= '0;
        req_generation <= '0;
        last <= 1'b1;
        hold_kind <= 1'b0;
        hold_slot <= '0;
        hold_entry <= '0;
        hold_stype <= '0;
        hold_gen <= '0;
        walk_cnt <= '0;
        ws <= slot_ptr;
        we <= entry_ptr;
      end
      if (cmd.walk_step) begin
        // One ring position per cycle; each new request releases the held result.
        if (emit) begin
          req_valid[ws] <= 1'b1;
          req_ent[ws] <= 10'(we);
          req_gen[ws] <= cur_gen;
          kind <= hold_kind;
          req_slot <= hold_slot;
          req_entry <= hold_entry;
          req_sampler_type <= hold_stype;
          req_generation <= hold_gen;
          last <= 1'b0;
          hold_kind <= 1'b1;
          hold_slot <= 4'(ws);
          hold_entry <= 10'(we);
          hold_stype <= cur_sampler;
          hold_gen <= cur_gen;
        end
        walk_cnt <= walk_cnt + RW'(1);
        ws <= ws_inc;
        we <= we_inc;
      end
      if (cmd.flush) begin
        kind <= hold_kind;
        req_slot <= hold_slot;
        req_entry <= hold_entry;
        req_sampler_type <= hold_stype;
        req_generation <= hold_gen;
        last <= 1'b1;
      end
    end
  end

endmodule
